// ===== hdl/dxtd_pkg.sv =====
// Shared types, codes and arithmetic helpers for the DXT block decoder.
// No dependencies; every other file in hdl imports this package.
package dxtd_pkg;

    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        ALPHA_PALETTE,
        ALPHA_EXPLICIT,
        ALPHA_RAMP
    } t_alpha_mode;

    typedef struct packed {
        logic [1:0]  format;
        logic [13:0] width;
        logic [13:0] height;
    } t_cfg;

    typedef struct packed {
        logic [3:0][31:0] pal;
        logic [7:0][7:0]  ramp;
        t_alpha_mode      alpha_mode;
        logic [63:0]      alpha_bits;
        logic [31:0]      color_idx;
        logic [3:0]       col_mask;
        logic [3:0]       row_ok;
        logic [12:0]      pixel_x;
        logic [12:0]      base_y;
        logic             image_last;
    } t_block_entry;

    // RGB565 to 8-bit channels by bit replication, R in the lowest byte.
    function automatic logic [23:0] expand565(input logic [15:0] c);
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
        r = c[15:11];
        g = c[10:5];
        b = c[4:0];
        return {b, b[4:2], g, g[5:4], r, r[4:2]};
    endfunction

    // Quotients by reciprocal multiplication, exact over the numerator ranges used.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = 20'(x) * 20'd683;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd4682;
        return p[22:15];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd6554;
        return p[22:15];
    endfunction

endpackage

// ===== hdl/dxtd_front.sv =====
// Front end: accepts compressed blocks, tracks the block position and builds
// the colour palette and alpha ramp. Depends on dxtd_pkg.
module dxtd_front
    import dxtd_pkg::*;
#(
    parameter int MAX_DIMENSION = 8192
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [127:0] i_data,
    output logic         o_push,
    output t_block_entry o_entry,
    input  logic         i_full
);

    logic [10:0]      r_col;
    logic [10:0]      r_row;
    logic             r_s1_valid;
    logic [2:0][7:0]  r_e0;
    logic [2:0][7:0]  r_e1;
    logic [2:0][7:0]  r_mid;
    logic [2:0][9:0]  r_n2;
    logic [2:0][9:0]  r_n3;
    logic             r_punch;
    logic [7:0]       r_a0;
    logic [7:0]       r_a1;
    logic             r_ramp7;
    logic [5:0][10:0] r_rnum;
    logic [31:0]      r_idx;
    logic [63:0]      r_abits;
    t_alpha_mode      r_mode;
    logic [3:0]       r_col_mask;
    logic [3:0]       r_row_ok;
    logic [12:0]      r_pixel_x;
    logic [12:0]      r_base_y;
    logic             r_image_last;

    logic             w_accept;
    logic [63:0]      w_abits;
    logic [63:0]      w_cbits;
    logic [2:0][7:0]  w_e0;
    logic [2:0][7:0]  w_e1;
    logic [2:0][7:0]  w_mid;
    logic [2:0][9:0]  w_n2;
    logic [2:0][9:0]  w_n3;
    logic [5:0][10:0] w_rnum;
    logic             w_ramp7;
    logic             w_punch;
    t_alpha_mode      w_mode;
    logic [13:0]      w_w;
    logic [13:0]      w_h;
    logic [12:0]      w_bw;
    logic [12:0]      w_bh;
    logic             w_last_col;
    logic             w_last_row;
    logic [12:0]      w_x0;
    logic [12:0]      w_y0;
    logic [3:0]       w_col_mask;
    logic [3:0]       w_row_ok;
    logic [10:0]      n_col;
    logic [10:0]      n_row;

    assign o_push   = r_s1_valid && !i_full;
    assign o_ready  = !r_s1_valid || !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_abits  = i_data[63:0];
    assign w_cbits  = i_data[127:64];

    always_comb begin
        logic [14:0] max_dim;
        logic [14:0] sum_w;
        logic [14:0] sum_h;
        max_dim = 15'(MAX_DIMENSION);
        if (i_cfg.width == 14'd0) begin
            w_w = 14'd1;
        end else if ({1'b0, i_cfg.width} > max_dim) begin
            w_w = max_dim[13:0];
        end else begin
            w_w = i_cfg.width;
        end
        if (i_cfg.height == 14'd0) begin
            w_h = 14'd1;
        end else if ({1'b0, i_cfg.height} > max_dim) begin
            w_h = max_dim[13:0];
        end else begin
            w_h = i_cfg.height;
        end
        sum_w      = {1'b0, w_w} + 15'd3;
        sum_h      = {1'b0, w_h} + 15'd3;
        w_bw       = sum_w[14:2];
        w_bh       = sum_h[14:2];
        w_last_col = ({2'b00, r_col} + 13'd1) >= w_bw;
        w_last_row = ({2'b00, r_row} + 13'd1) >= w_bh;
        w_x0       = {r_col, 2'b00};
        w_y0       = {r_row, 2'b00};
        for (int k = 0; k < 4; k++) begin
            w_col_mask[k] = ({1'b0, w_x0} + 14'(k)) < w_w;
            w_row_ok[k]   = ({1'b0, w_y0} + 14'(k)) < w_h;
        end
        if (w_last_col) begin
            n_col = 11'd0;
            n_row = w_last_row ? 11'd0 : r_row + 11'd1;
        end else begin
            n_col = r_col + 11'd1;
            n_row = r_row;
        end
    end

    always_comb begin
        logic [8:0] sum;
        w_e0    = expand565(w_cbits[15:0]);
        w_e1    = expand565(w_cbits[31:16]);
        w_punch = (i_cfg.format == FMT_DXT1) && (w_cbits[15:0] <= w_cbits[31:16]);
        for (int ch = 0; ch < 3; ch++) begin
            w_n2[ch]  = {1'b0, w_e0[ch], 1'b0} + {2'b00, w_e1[ch]} + 10'd1;
            w_n3[ch]  = {2'b00, w_e0[ch]} + {1'b0, w_e1[ch], 1'b0} + 10'd1;
            sum       = {1'b0, w_e0[ch]} + {1'b0, w_e1[ch]};
            w_mid[ch] = sum[8:1];
        end
        w_ramp7 = w_abits[7:0] > w_abits[15:8];
        for (int j = 0; j < 6; j++) begin
            if (w_ramp7) begin
                w_rnum[j] = 11'(6 - j) * {3'b000, w_abits[7:0]}
                          + 11'(j + 1) * {3'b000, w_abits[15:8]} + 11'd3;
            end else if (j < 4) begin
                w_rnum[j] = 11'(4 - j) * {3'b000, w_abits[7:0]}
                          + 11'(j + 1) * {3'b000, w_abits[15:8]} + 11'd2;
            end else begin
                w_rnum[j] = 11'd0;
            end
        end
        case (i_cfg.format)
            FMT_DXT1: w_mode = ALPHA_PALETTE;
            FMT_DXT3: w_mode = ALPHA_EXPLICIT;
            default:  w_mode = ALPHA_RAMP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_col      <= 11'd0;
            r_row      <= 11'd0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
                r_col      <= n_col;
                r_row      <= n_row;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e0         <= w_e0;
            r_e1         <= w_e1;
            r_mid        <= w_mid;
            r_n2         <= w_n2;
            r_n3         <= w_n3;
            r_punch      <= w_punch;
            r_a0         <= w_abits[7:0];
            r_a1         <= w_abits[15:8];
            r_ramp7      <= w_ramp7;
            r_rnum       <= w_rnum;
            r_idx        <= w_cbits[63:32];
            r_abits      <= w_abits;
            r_mode       <= w_mode;
            r_col_mask   <= w_col_mask;
            r_row_ok     <= w_row_ok;
            r_pixel_x    <= w_x0;
            r_base_y     <= w_y0;
            r_image_last <= w_last_col && w_last_row;
        end
    end

    always_comb begin
        logic [2:0][7:0] d2;
        logic [2:0][7:0] d3;
        for (int ch = 0; ch < 3; ch++) begin
            d2[ch] = div3(r_n2[ch]);
            d3[ch] = div3(r_n3[ch]);
        end
        o_entry.pal[0] = {8'hFF, r_e0};
        o_entry.pal[1] = {8'hFF, r_e1};
        o_entry.pal[2] = {8'hFF, (r_punch ? r_mid : d2)};
        o_entry.pal[3] = r_punch ? 32'd0 : {8'hFF, d3};
        o_entry.ramp[0] = r_a0;
        o_entry.ramp[1] = r_a1;
        for (int j = 0; j < 6; j++) begin
            if (r_ramp7) begin
                o_entry.ramp[j + 2] = div7(r_rnum[j]);
            end else if (j < 4) begin
                o_entry.ramp[j + 2] = div5(r_rnum[j]);
            end else if (j == 4) begin
                o_entry.ramp[j + 2] = 8'h00;
            end else begin
                o_entry.ramp[j + 2] = 8'hFF;
            end
        end
        o_entry.alpha_mode = r_mode;
        o_entry.alpha_bits = r_abits;
        o_entry.color_idx  = r_idx;
        o_entry.col_mask   = r_col_mask;
        o_entry.row_ok     = r_row_ok;
        o_entry.pixel_x    = r_pixel_x;
        o_entry.base_y     = r_base_y;
        o_entry.image_last = r_image_last;
    end

endmodule

// ===== hdl/dxtd_fifo.sv =====
// Short queue of decoded block descriptors between the front and back ends.
// Depends on dxtd_pkg for the entry type and depth.
module dxtd_fifo
    import dxtd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_block_entry i_data,
    output logic         o_full,
    input  logic         i_pop,
    output t_block_entry o_data,
    output logic         o_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_block_entry r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = r_count == CNT_W'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/dxtd_back.sv =====
// Back end: walks each queued block row by row and registers one row of four
// RGBA texels with its position per cycle while not stalled. Depends on dxtd_pkg.
module dxtd_back
    import dxtd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_block_entry     i_entry,
    input  logic             i_entry_valid,
    output logic             o_pop,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [3:0][31:0] o_texels,
    output logic [3:0]       o_edge_mask,
    output logic [12:0]      o_pixel_x,
    output logic [12:0]      o_pixel_y,
    output logic             o_block_done,
    output logic             o_image_done
);

    logic             r_valid;
    logic [1:0]       r_row;
    logic [3:0][31:0] r_texels;
    logic [3:0]       r_edge_mask;
    logic [12:0]      r_pixel_x;
    logic [12:0]      r_pixel_y;
    logic             r_block_done;
    logic             r_image_done;

    logic             w_load;
    logic [3:0][31:0] n_texels;

    assign w_load = !r_valid || i_ready;
    assign o_pop  = w_load && i_entry_valid && (r_row == 2'd3);

    always_comb begin
        logic [3:0]  t;
        logic [1:0]  ci;
        logic [3:0]  nib;
        logic [5:0]  apos;
        logic [2:0]  ai;
        logic [31:0] texel;
        for (int k = 0; k < 4; k++) begin
            t     = {r_row, 2'(k)};
            ci    = i_entry.color_idx[{t, 1'b0} +: 2];
            texel = i_entry.pal[ci];
            nib   = i_entry.alpha_bits[{t, 2'b00} +: 4];
            apos  = 6'd16 + 6'(t) * 6'd3;
            ai    = i_entry.alpha_bits[apos +: 3];
            case (i_entry.alpha_mode)
                ALPHA_EXPLICIT: n_texels[k] = {nib, nib, texel[23:0]};
                ALPHA_RAMP:     n_texels[k] = {i_entry.ramp[ai], texel[23:0]};
                default:        n_texels[k] = texel;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_row   <= 2'd0;
        end else if (w_load) begin
            r_valid <= i_entry_valid;
            if (i_entry_valid) begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_entry_valid) begin
            r_texels     <= n_texels;
            r_edge_mask  <= i_entry.row_ok[r_row] ? i_entry.col_mask : 4'd0;
            r_pixel_x    <= i_entry.pixel_x;
            r_pixel_y    <= {i_entry.base_y[12:2], r_row};
            r_block_done <= r_row == 2'd3;
            r_image_done <= (r_row == 2'd3) && i_entry.image_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_texels     = r_texels;
    assign o_edge_mask  = r_edge_mask;
    assign o_pixel_x    = r_pixel_x;
    assign o_pixel_y    = r_pixel_y;
    assign o_block_done = r_block_done;
    assign o_image_done = r_image_done;

    a_image_done_on_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_image_done |-> r_block_done)
        else $error("image end flagged on a row that does not end its block");

    a_last_row_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_block_done |-> r_pixel_y[1:0] == 2'b11)
        else $error("block end flagged away from the fourth row");

    a_rows_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_ready && !r_block_done |=>
            r_valid && r_pixel_y == $past(r_pixel_y) + 13'd1
            && r_pixel_x == $past(r_pixel_x))
        else $error("next row of a block did not follow at once");

endmodule

// ===== hdl/dxt_block_decoder.sv =====
// Top level of the S3TC/DXT block decoder: register port, front end, queue
// and back end. Depends on dxtd_pkg, dxtd_front, dxtd_fifo and dxtd_back.
//
//  Channel   Direction  Width  Contents
//  s_axis    in         128    one compressed 4x4 block per request
//  m_axis    out        160    one row of four RGBA texels with position
//  apb       in/out     32     block_format, image_width, image_height
//
// A block leaves the output as its four rows, one row per cycle while the output is
// not stalled; the single output row register sets the sustained block rate.
// An accepted block passes the front-end register and the queue before its first row is valid.
// Reset is synchronous: block counters clear, format 0, width and height 4.
// Stalls on the output fill a two-entry queue before the input stalls.
module dxt_block_decoder
    import dxtd_pkg::*;
#(
    parameter int MAX_DIMENSION = 8192
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // alpha_bits, color_bits
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,  // texel_0..3, edge_mask, pixel_x, pixel_y, zeros
    output logic         m_axis_tlast,
    output logic         m_axis_tuser,  // image_done
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    logic [1:0]       r_format;
    logic [13:0]      r_width;
    logic [13:0]      r_height;
    t_cfg             w_cfg;
    logic             w_push;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;
    t_block_entry     w_wr_entry;
    t_block_entry     w_rd_entry;
    logic [3:0][31:0] w_texels;
    logic [3:0]       w_edge_mask;
    logic [12:0]      w_pixel_x;
    logic [12:0]      w_pixel_y;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= 2'd0;
            r_width  <= 14'd4;
            r_height <= 14'd4;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_FORMAT: r_format <= pwdata[1:0];
                REG_WIDTH:  r_width  <= pwdata[13:0];
                REG_HEIGHT: r_height <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FORMAT: prdata = {30'd0, r_format};
            REG_WIDTH:  prdata = {18'd0, r_width};
            REG_HEIGHT: prdata = {18'd0, r_height};
            default:    prdata = 32'd0;
        endcase
    end

    assign w_cfg.format = r_format;
    assign w_cfg.width  = r_width;
    assign w_cfg.height = r_height;

    dxtd_front #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_push  (w_push),
        .o_entry (w_wr_entry),
        .i_full  (w_full)
    );

    dxtd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_wr_entry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_rd_entry),
        .o_empty (w_empty)
    );

    dxtd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_rd_entry),
        .i_entry_valid (!w_empty),
        .o_pop         (w_pop),
        .i_ready       (m_axis_tready),
        .o_valid       (m_axis_tvalid),
        .o_texels      (w_texels),
        .o_edge_mask   (w_edge_mask),
        .o_pixel_x     (w_pixel_x),
        .o_pixel_y     (w_pixel_y),
        .o_block_done  (m_axis_tlast),
        .o_image_done  (m_axis_tuser)
    );

    assign m_axis_tdata = {2'b00, w_pixel_y, w_pixel_x, w_edge_mask, w_texels};

endmodule

// ===== verif/dxtd_tb_pkg.sv =====
// Codes and the row record shared by the DXT block decoder testbench files.
// Depends on nothing; the checker and the testbench top import it.
package dxtd_tb_pkg;

    localparam logic [1:0] FMT_DXT5  = 2'd2;
    localparam logic [1:0] FMT_SPARE = 2'd3;

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;
    localparam logic [1:0] REG_SPARE  = 2'd3;

    typedef struct packed {
        logic [3:0][31:0] texel;
        logic [3:0]       edge_mask;
        logic [12:0]      pixel_x;
        logic [12:0]      pixel_y;
        logic             block_done;
        logic             image_done;
    } t_texel_row;

endpackage

// ===== verif/dxt_block_decoder_checker.sv =====
// Checker for the DXT block decoder: follows register writes, decodes every accepted
// block into its four expected rows and compares each emitted row field by field.
// Depends on dxtd_pkg and dxtd_tb_pkg.
module dxt_block_decoder_checker
    import dxtd_pkg::*;
    import dxtd_tb_pkg::*;
#(
    parameter int MAX_DIMENSION = 8192
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [159:0] m_axis_tdata,
    input  logic         m_axis_tlast,
    input  logic         m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_rows_pending,
    output int           o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]  fmt;
    logic [13:0] cfg_width;
    logic [13:0] cfg_height;
    logic [10:0] blk_col;
    logic [10:0] blk_row;
    t_texel_row  rows_due[$];
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic int clamp_dim(input logic [13:0] v);
        if (v == 14'd0) return 1;
        if (int'(v) > MAX_DIMENSION) return MAX_DIMENSION;
        return int'(v);
    endfunction

    function automatic int channel565(input logic [15:0] c, input int k);
        int v;
        case (k)
            0: v = (int'(c[15:11]) << 3) | (int'(c[15:11]) >> 2);
            1: v = (int'(c[10:5]) << 2) | (int'(c[10:5]) >> 4);
            default: v = (int'(c[4:0]) << 3) | (int'(c[4:0]) >> 2);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pack_rgba(input int r, input int g, input int b,
                                              input int a);
        return {a[7:0], b[7:0], g[7:0], r[7:0]};
    endfunction

    function automatic void decode_block(input logic [63:0] abits, input logic [63:0] cbits);
        int          w, h, bw, bh, a0, a1, y, x0, t;
        bit          last_col, last_row;
        int          e0[3];
        int          e1[3];
        int          ramp[8];
        logic [31:0] pal[4];
        logic [31:0] texel;
        logic [3:0]  nib;
        t_texel_row  row;

        w = clamp_dim(cfg_width);
        h = clamp_dim(cfg_height);
        bw = (w + 3) / 4;
        bh = (h + 3) / 4;
        last_col = int'(blk_col) + 1 >= bw;
        last_row = int'(blk_row) + 1 >= bh;

        for (int i = 0; i < 3; i++) begin
            e0[i] = channel565(cbits[15:0], i);
            e1[i] = channel565(cbits[31:16], i);
        end
        pal[0] = pack_rgba(e0[0], e0[1], e0[2], 255);
        pal[1] = pack_rgba(e1[0], e1[1], e1[2], 255);
        if (fmt == FMT_DXT1 && cbits[15:0] <= cbits[31:16]) begin
            pal[2] = pack_rgba((e0[0] + e1[0]) / 2, (e0[1] + e1[1]) / 2,
                               (e0[2] + e1[2]) / 2, 255);
            pal[3] = 32'd0;
        end else begin
            pal[2] = pack_rgba((2 * e0[0] + e1[0] + 1) / 3, (2 * e0[1] + e1[1] + 1) / 3,
                               (2 * e0[2] + e1[2] + 1) / 3, 255);
            pal[3] = pack_rgba((e0[0] + 2 * e1[0] + 1) / 3, (e0[1] + 2 * e1[1] + 1) / 3,
                               (e0[2] + 2 * e1[2] + 1) / 3, 255);
        end

        a0 = int'(abits[7:0]);
        a1 = int'(abits[15:8]);
        ramp[0] = a0;
        ramp[1] = a1;
        if (a0 > a1) begin
            for (int i = 1; i <= 6; i++)
                ramp[i + 1] = ((7 - i) * a0 + i * a1 + 3) / 7;
        end else begin
            for (int i = 1; i <= 4; i++)
                ramp[i + 1] = ((5 - i) * a0 + i * a1 + 2) / 5;
            ramp[6] = 0;
            ramp[7] = 255;
        end

        for (int r = 0; r < 4; r++) begin
            y = int'(blk_row) * 4 + r;
            x0 = int'(blk_col) * 4;
            row = '0;
            for (int k = 0; k < 4; k++) begin
                t = r * 4 + k;
                texel = pal[cbits[32 + 2 * t +: 2]];
                if (fmt == FMT_DXT3) begin
                    nib = abits[4 * t +: 4];
                    texel[31:24] = {nib, nib};
                end else if (fmt == FMT_DXT5 || fmt == FMT_SPARE) begin
                    texel[31:24] = 8'(ramp[abits[16 + 3 * t +: 3]]);
                end
                row.texel[k] = texel;
                if (y < h && x0 + k < w) row.edge_mask[k] = 1'b1;
            end
            row.pixel_x = 13'(x0);
            row.pixel_y = 13'(y);
            row.block_done = (r == 3);
            row.image_done = (r == 3) && last_col && last_row;
            rows_due.insert(rows_due.size(), row);
        end

        if (last_col) begin
            blk_col = '0;
            blk_row = last_row ? 11'd0 : blk_row + 11'd1;
        end else begin
            blk_col = blk_col + 11'd1;
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_row(input t_texel_row got);
        t_texel_row want;
        if (rows_due.size() == 0) begin
            $error("row at pixel_y %0d emitted with nothing expected", got.pixel_y);
            fail_count++;
            return;
        end
        want = rows_due.pop_front();
        for (int k = 0; k < 4; k++)
            check_field($sformatf("texel_%0d", k), want.texel[k], got.texel[k]);
        check_field("edge_mask", 32'(want.edge_mask), 32'(got.edge_mask));
        check_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
        check_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
        check_field("block_done", 32'(want.block_done), 32'(got.block_done));
        check_field("image_done", 32'(want.image_done), 32'(got.image_done));
    endfunction

    always @(posedge i_clk) begin
        t_texel_row got;
        if (!i_rst_n) begin
            fmt = FMT_DXT1;
            cfg_width = 14'd4;
            cfg_height = 14'd4;
            blk_col = '0;
            blk_row = '0;
            rows_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_FORMAT: fmt = pwdata[1:0];
                    REG_WIDTH:  cfg_width = pwdata[13:0];
                    REG_HEIGHT: cfg_height = pwdata[13:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_block(s_axis_tdata[63:0], s_axis_tdata[127:64]);
            if (m_axis_tvalid && m_axis_tready) begin
                got.texel = m_axis_tdata[127:0];
                got.edge_mask = m_axis_tdata[131:128];
                got.pixel_x = m_axis_tdata[144:132];
                got.pixel_y = m_axis_tdata[157:145];
                got.block_done = m_axis_tlast;
                got.image_done = m_axis_tuser;
                check_row(got);
            end
        end
        o_rows_pending <= rows_due.size();
    end

endmodule

// ===== verif/dxt_block_decoder_tb.sv =====
// Testbench top for the DXT block decoder: clock, reset, register writes, block
// requests and output back-pressure, with the verdict taken from the checker.
// Depends on dxtd_pkg, dxtd_tb_pkg, dxt_block_decoder_checker and dxt_block_decoder.
module dxt_block_decoder_tb
    import dxtd_pkg::*;
    import dxtd_tb_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIMENSION = 8192;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_ITEMS = 41;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           rows_pending;
    int           fail_count;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;

    dxt_block_decoder #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    dxt_block_decoder_checker #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .pready(pready),
        .o_rows_pending(rows_pending),
        .o_fail_count(fail_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // A long hold-off lets the queue fill so that the block stalls its input.
    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [1:0] fmt, input logic [13:0] width,
                             input logic [13:0] height);
        apb_write(REG_FORMAT, {30'($urandom), fmt});
        apb_write(REG_WIDTH, {18'($urandom), width});
        apb_write(REG_HEIGHT, {18'($urandom), height});
    endtask

    task automatic send_block(input logic [63:0] alpha_bits, input logic [63:0] color_bits);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {color_bits, alpha_bits};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (rows_pending != 0);
    endtask

    function automatic logic [13:0] pick_dimension();
        case ($urandom_range(0, 11))
            0: return 14'd0;
            1: return 14'd8192;
            2: return 14'h3FFF;
            3: return 14'd1;
            default: return 14'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [127:0] random_block();
        logic [63:0] a;
        logic [63:0] c;
        a = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: c[31:16] = c[15:0];
            1: a[15:8] = a[7:0];
            default: ;
        endcase
        return {c, a};
    endfunction

    initial begin
        logic [47:0]  ramp_walk;
        logic [127:0] blk;

        for (int i = 0; i < 16; i++)
            ramp_walk[3 * i +: 3] = 3'(i % 8);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opaque and punch-through colour blocks under the reset settings.
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h0, {32'hE4E4_E4E4, 16'h0000, 16'hFFFF});
        send_block(64'h0, {32'hE4E4_E4E4, 16'hFFFF, 16'h0000});
        send_block({$urandom, $urandom}, {$urandom, 16'h07E0, 16'hF800});
        wait_drained();

        // Explicit alpha on a clipped 2x2-block image.
        configure(FMT_DXT3, 14'd5, 14'd7);
        send_block(64'h0, {32'hE4E4_E4E4, 16'h1234, 16'hABCD});
        send_block('1, {$urandom, $urandom});
        send_block(64'hFEDC_BA98_7654_3210, {32'h1B1B_1B1B, 16'h0000, 16'hFFFF});
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        wait_drained();

        // Interpolated alpha, both ramp kinds, with zero dimensions.
        configure(FMT_DXT5, 14'd0, 14'd0);
        send_block({ramp_walk, 8'd0, 8'd255}, {$urandom, $urandom});
        send_block({ramp_walk, 8'd255, 8'd0}, {$urandom, $urandom});
        send_block({ramp_walk, 8'h80, 8'h80}, {$urandom, $urandom});
        send_block({ramp_walk, 8'd0, 8'd1}, {$urandom, $urandom});
        wait_drained();

        // Unused format code with oversize dimensions.
        configure(FMT_SPARE, 14'h3FFF, 14'd8193);
        send_block({ramp_walk, 8'd40, 8'd200}, {$urandom, $urandom});
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        wait_drained();

        // Full width, then a shrink that leaves the column counter beyond the edge.
        configure(FMT_DXT1, 14'd8192, 14'd4);
        apb_write(REG_SPARE, 32'hFFFF_FFFF);
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        wait_drained();
        apb_write(REG_WIDTH, 32'd1);
        send_block({$urandom, $urandom}, {$urandom, 16'h0001, 16'h0001});
        send_block({$urandom, $urandom}, {$urandom, $urandom});
        wait_drained();

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            configure(2'($urandom_range(0, 3)), pick_dimension(), pick_dimension());
            case (seg % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 55;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 55;
                end
                default: begin
                    send_idle_pct = 33;
                    stall_pct = 33;
                end
            endcase
            if (seg == 4) hold_requests++;
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                blk = random_block();
                send_block(blk[63:0], blk[127:64]);
            end
            wait_drained();
        end

        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && rows_pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
